[rtl/smm_pkg.sv]
`timescale 1ns / 1ps

package smm_pkg;

  localparam int SIG_MAX_BYTES = 16;
  localparam int SIG_IDX_W = $clog2(SIG_MAX_BYTES);
  localparam int LEN_W = 5;
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH = 3'd5;

  // Verdict codes
  localparam logic [1:0] VERDICT_MATCH = 2'd0;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
  localparam logic [1:0] VERDICT_DROPPED = 2'd2;

  typedef struct packed {
    logic [15:0] offset;
    logic [LEN_W-1:0] length;
    logic [SIG_MAX_BYTES-1:0][7:0] magic;
    logic [SIG_MAX_BYTES-1:0][7:0] mask;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic dropped;
    logic mismatch;
  } rec_end_t;

endpackage

[rtl/smm_cfg_regs.sv]
`timescale 1ns / 1ps

module smm_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [smm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  output smm_pkg::cfg_t cfg
);
  import smm_pkg::*;

  logic [15:0] sig_offset;
  logic [LEN_W-1:0] sig_length;
  logic [63:0] magic_low;
  logic [63:0] magic_high;
  logic [63:0] mask_low;
  logic [63:0] mask_high;
  logic [LEN_W-1:0] eff_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_offset <= '0;
      sig_length <= LEN_W'(1);
      magic_low <= '0;
      magic_high <= '0;
      mask_low <= '1;
      mask_high <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIG_OFFSET: sig_offset <= cfg_data[15:0];
        REG_SIG_LENGTH: sig_length <= cfg_data[LEN_W-1:0];
        REG_MAGIC_LOW:  magic_low <= cfg_data;
        REG_MAGIC_HIGH: magic_high <= cfg_data;
        REG_MASK_LOW:   mask_low <= cfg_data;
        REG_MASK_HIGH:  mask_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // A length of zero counts as one byte; anything beyond the maximum is clamped.
  always_comb begin
    if (sig_length == '0) begin
      eff_length = LEN_W'(1);
    end else if (sig_length > LEN_W'(SIG_MAX_BYTES)) begin
      eff_length = LEN_W'(SIG_MAX_BYTES);
    end else begin
      eff_length = sig_length;
    end
  end

  assign cfg.offset = sig_offset;
  assign cfg.length = eff_length;
  assign cfg.magic = {magic_high, magic_low};
  assign cfg.mask = {mask_high, mask_low};

endmodule

[rtl/smm_byte_check.sv]
`timescale 1ns / 1ps

module smm_byte_check (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  input  smm_pkg::cfg_t cfg,
  input  logic result_free,
  output smm_pkg::rec_end_t rec_end
);
  import smm_pkg::*;

  logic s1_valid;
  logic [7:0] s1_byte;
  logic s1_last;
  logic [POS_W-1:0] byte_position;
  logic mismatch_seen;

  logic advance;
  logic accept;
  logic [POS_W-1:0] win_start;
  logic [POS_W-1:0] win_end;
  logic [POS_W-1:0] win_rel;
  logic [SIG_IDX_W-1:0] win_idx;
  logic in_window;
  logic byte_miss;
  logic mismatch_next;
  logic [POS_W-1:0] rec_len;

  // A word that carries no result always moves on; the final word of a
  // record waits for room in the result register.
  assign advance = s1_valid && (!s1_last || result_free);
  assign in_stall = s1_valid && !advance;
  assign accept = in_valid && !in_stall;

  assign win_start = POS_W'(cfg.offset);
  assign win_end = win_start + POS_W'(cfg.length);
  assign win_rel = byte_position - win_start;
  assign win_idx = win_rel[SIG_IDX_W-1:0];
  assign in_window = (byte_position >= win_start) && (byte_position < win_end);
  assign byte_miss = ((s1_byte ^ cfg.magic[win_idx]) & cfg.mask[win_idx] & BYTE_MASK) != 8'h00;
  assign mismatch_next = mismatch_seen || (in_window && byte_miss);
  assign rec_len = (byte_position == POS_MAX) ? POS_MAX : byte_position + POS_W'(1);

  assign rec_end.fire = advance && s1_last;
  assign rec_end.dropped = win_end > rec_len;
  assign rec_end.mismatch = mismatch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      mismatch_seen <= 1'b0;
    end else if (advance) begin
      if (s1_last) begin
        byte_position <= '0;
        mismatch_seen <= 1'b0;
      end else begin
        byte_position <= rec_len;
        mismatch_seen <= mismatch_next;
      end
    end
  end

endmodule

[rtl/smm_result.sv]
`timescale 1ns / 1ps

module smm_result (
  input  logic clk,
  input  logic rst,
  input  smm_pkg::rec_end_t rec_end,
  output logic result_free,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] verdict,
  output logic [63:0] checked_count,
  output logic [63:0] matched_count,
  output logic [63:0] unmatched_count
);
  import smm_pkg::*;

  logic [1:0] verdict_next;

  assign result_free = !out_valid || !out_stall;

  always_comb begin
    if (rec_end.dropped) begin
      verdict_next = VERDICT_DROPPED;
    end else if (rec_end.mismatch) begin
      verdict_next = VERDICT_MISMATCH;
    end else begin
      verdict_next = VERDICT_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_end.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_end.fire) begin
      verdict <= verdict_next;
    end
  end

  // The counters only move when a new word is loaded, so they double as the
  // count fields of the word on show.
  always_ff @(posedge clk) begin
    if (rst) begin
      checked_count <= '0;
      matched_count <= '0;
      unmatched_count <= '0;
    end else if (rec_end.fire && !rec_end.dropped) begin
      checked_count <= checked_count + 64'd1;
      if (rec_end.mismatch) begin
        unmatched_count <= unmatched_count + 64'd1;
      end else begin
        matched_count <= matched_count + 64'd1;
      end
    end
  end

endmodule

[rtl/masked_signature_matcher_core.sv]
// A record's final byte is registered, and its verdict word then loads into the result register.
// Throughput: one byte per cycle unless stalled, set by the single input and result registers.
// The input stalls only while a finished verdict word is held back by the output.
// Reset (synchronous, active high) clears the record position, the mismatch flag,
// the three counters and all handshake state, and loads the register defaults.
`timescale 1ns / 1ps

module masked_signature_matcher_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [smm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] verdict,
  output logic [63:0] checked_count,
  output logic [63:0] matched_count,
  output logic [63:0] unmatched_count
);
  import smm_pkg::*;

  cfg_t cfg;
  rec_end_t rec_end;
  logic result_free;

  smm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smm_byte_check u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .cfg         (cfg),
    .result_free (result_free),
    .rec_end     (rec_end)
  );

  smm_result u_result (
    .clk             (clk),
    .rst             (rst),
    .rec_end         (rec_end),
    .result_free     (result_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .verdict         (verdict),
    .checked_count   (checked_count),
    .matched_count   (matched_count),
    .unmatched_count (unmatched_count)
  );

endmodule

[rtl/smm_checker.sv]
`timescale 1ns / 1ps

module smm_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] verdict,
  input logic [63:0] checked_count,
  input logic [63:0] matched_count,
  input logic [63:0] unmatched_count
);
  import smm_pkg::*;

  // A word held back by the output must stay on show.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("verdict word dropped while stalled");

  // The input can only be held up by a stalled output.
  assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled although the output is free");

  // Every checked record is either matched or unmatched.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> checked_count == matched_count + unmatched_count)
    else $error("counters disagree");

  // The checked count moves by one, and only with a new non-dropped word.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(checked_count) |->
      out_valid && verdict != VERDICT_DROPPED &&
      checked_count == $past(checked_count) + 64'd1)
    else $error("checked count moved unexpectedly");

endmodule

bind masked_signature_matcher_core smm_checker u_smm_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .verdict         (verdict),
  .checked_count   (checked_count),
  .matched_count   (matched_count),
  .unmatched_count (unmatched_count)
);
